// ----- sv/psort_pkg.sv -----
`default_nettype none
package psort_pkg;

  // field widths of a request and of a result
  localparam int DAYS_W = 10;
  localparam int WAGE_W = 32;
  localparam int PAY_W  = 42;
  localparam int IDX_W  = 6;

  // default capacity of the record store
  localparam int MAX_RECORDS_DEF = 64;

  // one stored record
  typedef struct packed {
    logic [PAY_W-1:0] pay;
    logic [IDX_W-1:0] idx;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDI,
    ST_HOLD,
    ST_SCAN,
    ST_WBI,
    ST_OUT
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic hold_load;
    logic scan_cmp;
    logic wsel_load;
  } dp_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/pay_exchange_sorter.sv -----
`default_nettype none
// Pay record sorter.
// Request channel: a record (days worked, daily wage, last flag) is taken at a
// rising edge with start high and busy low. Each record is stored
// as pay = days * wage with its arrival index; busy stays low while loading.
// Once MAX_RECORDS are held, further records are dropped and the set is
// flagged with overflow.
// A request with in_last_record set closes the set. busy then rises and the
// stored records are sorted in descending pay order by an exchange sort run
// on one compare unit and a single-write, single-read record RAM, with one
// compare per cycle.
// Results follow once the sort ends, one per cycle on out_valid, read from the
// registered RAM port; out_final_result marks the last. busy drops together
// with the final strobe, so the next set may start in that cycle.
// The receiver cannot stall: each result is present for one cycle only.
// Reset (synchronous, active low) empties the set and returns to idle; the
// record RAM needs no clearing.
module pay_exchange_sorter #(
  parameter int MAX_RECORDS = psort_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [psort_pkg::DAYS_W-1:0]  in_days_worked,
  input  wire logic [psort_pkg::WAGE_W-1:0]  in_daily_wage,
  input  wire logic                          in_last_record,
  output      logic                          out_valid,
  output      logic [psort_pkg::IDX_W-1:0]   out_record_index,
  output      logic [psort_pkg::PAY_W-1:0]   out_net_pay,
  output      logic                          out_final_result,
  output      logic                          out_overflow
);

  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int ADDR_W = $clog2(MAX_RECORDS);

  psort_pkg::dp_ctrl_t         ctrl;
  psort_pkg::entry_t           rd_data, wdata;
  logic                        gt, ram_we;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [psort_pkg::IDX_W-1:0] rec_idx;

  // sequencer
  psort_seq #(
    .MAX_RECORDS (MAX_RECORDS),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last      (in_last_record),
    .gt        (gt),
    .busy      (busy),
    .ctrl      (ctrl),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .rec_idx   (rec_idx),
    .out_valid (out_valid),
    .out_final (out_final_result),
    .out_ovf   (out_overflow)
  );

  // multiplier, held entry and shared compare
  psort_dp u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .days    (in_days_worked),
    .wage    (in_daily_wage),
    .rec_idx (rec_idx),
    .rd_data (rd_data),
    .wdata   (wdata),
    .gt      (gt)
  );

  // record store
  psort_ram #(
    .DEPTH  (MAX_RECORDS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // results come straight from the registered RAM read
  assign out_record_index = rd_data.idx;
  assign out_net_pay      = rd_data.pay;

`ifndef NO_ASSERTIONS
  // a record that does not close the set never makes the block busy
  a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_record) |=> !busy)
    else $error("busy raised by an ordinary record");

  // closing the set always starts the sort or output run
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_record) |=> busy)
    else $error("closing record did not start a run");

  // every result but the final one arrives while still busy
  a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_result) |-> busy)
    else $error("result strobe after the run ended");

  // the final result ends the run in that very cycle
  a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_result) |-> !busy)
    else $error("run continued past the final result");
`endif

endmodule
`default_nettype wire

// ----- sv/psort_ram.sv -----
`default_nettype none
module psort_ram #(
  parameter int DEPTH  = psort_pkg::MAX_RECORDS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   waddr,
  input  wire psort_pkg::entry_t   wdata,
  input  wire logic [ADDR_W-1:0]   raddr,
  output      psort_pkg::entry_t   rdata
);

  psort_pkg::entry_t mem [DEPTH];
  psort_pkg::entry_t rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- sv/psort_dp.sv -----
`default_nettype none
module psort_dp (
  input  wire logic                           clk,
  input  wire psort_pkg::dp_ctrl_t            ctrl,
  input  wire logic [psort_pkg::DAYS_W-1:0]   days,
  input  wire logic [psort_pkg::WAGE_W-1:0]   wage,
  input  wire logic [psort_pkg::IDX_W-1:0]    rec_idx,
  input  wire psort_pkg::entry_t              rd_data,
  output      psort_pkg::entry_t              wdata,
  output      logic                           gt
);

  logic [psort_pkg::PAY_W-1:0] prod;
  psort_pkg::entry_t           held_r;

  // pay of an incoming record, written straight into the store
  assign prod = psort_pkg::PAY_W'(days) * psort_pkg::PAY_W'(wage);

  // shared compare: later entry strictly above the held one
  assign gt = rd_data.pay > held_r.pay;

  // held entry for position i; takes the larger entry on a swap
  always_ff @(posedge clk) begin
    if (ctrl.hold_load || (ctrl.scan_cmp && gt)) begin
      held_r <= rd_data;
    end
  end

  // write data: new record on load, else the displaced held entry
  always_comb begin
    if (ctrl.wsel_load) begin
      wdata.pay = prod;
      wdata.idx = rec_idx;
    end else begin
      wdata = held_r;
    end
  end

endmodule
`default_nettype wire

// ----- sv/psort_seq.sv -----
`default_nettype none
module psort_seq #(
  parameter int MAX_RECORDS = psort_pkg::MAX_RECORDS_DEF,
  parameter int CNT_W       = $clog2(MAX_RECORDS + 1),
  parameter int ADDR_W      = $clog2(MAX_RECORDS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          last,
  input  wire logic                          gt,
  output      logic                          busy,
  output      psort_pkg::dp_ctrl_t           ctrl,
  output      logic                          ram_we,
  output      logic [ADDR_W-1:0]             ram_waddr,
  output      logic [ADDR_W-1:0]             ram_raddr,
  output      logic [psort_pkg::IDX_W-1:0]   rec_idx,
  output      logic                          out_valid,
  output      logic                          out_final,
  output      logic                          out_ovf
);

  psort_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  i_r, j_r, jd_r, k_r;
  logic              dropped_r;
  logic              out_valid_r, out_final_r, out_ovf_r;
  logic              accept, room, scan_end, sort_end, out_end;

  assign accept   = start && (state_r == psort_pkg::ST_IDLE);
  assign room     = count_r != CNT_W'(MAX_RECORDS);
  assign scan_end = (jd_r + CNT_W'(1)) == count_r;
  assign sort_end = (i_r + CNT_W'(2)) == count_r;
  assign out_end  = (k_r + CNT_W'(1)) == count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psort_pkg::ST_IDLE: begin
        if (accept && last) begin
          // a set of one record needs no sort
          state_nxt = (!room || (count_r != '0)) ? psort_pkg::ST_RDI : psort_pkg::ST_OUT;
        end
      end
      psort_pkg::ST_RDI:  state_nxt = psort_pkg::ST_HOLD;
      psort_pkg::ST_HOLD: state_nxt = psort_pkg::ST_SCAN;
      psort_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = psort_pkg::ST_WBI;
      end
      psort_pkg::ST_WBI:  state_nxt = sort_end ? psort_pkg::ST_OUT : psort_pkg::ST_RDI;
      psort_pkg::ST_OUT: begin
        if (out_end) state_nxt = psort_pkg::ST_IDLE;
      end
      default: state_nxt = psort_pkg::ST_IDLE;
    endcase
  end

  // store and datapath controls
  always_comb begin
    ctrl.hold_load = (state_r == psort_pkg::ST_HOLD);
    ctrl.scan_cmp  = (state_r == psort_pkg::ST_SCAN);
    ctrl.wsel_load = (state_r == psort_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = i_r[ADDR_W-1:0];
    ram_raddr = i_r[ADDR_W-1:0];
    case (state_r)
      psort_pkg::ST_IDLE: begin
        ram_we    = accept && room;
        ram_waddr = count_r[ADDR_W-1:0];
        ram_raddr = k_r[ADDR_W-1:0];
      end
      psort_pkg::ST_RDI: begin
        ram_raddr = i_r[ADDR_W-1:0];
      end
      psort_pkg::ST_HOLD: begin
        ram_raddr = j_r[ADDR_W-1:0];
      end
      psort_pkg::ST_SCAN: begin
        // displaced held entry drops into slot jd, the one just compared
        ram_we    = gt;
        ram_waddr = jd_r[ADDR_W-1:0];
        ram_raddr = j_r[ADDR_W-1:0];
      end
      psort_pkg::ST_WBI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[ADDR_W-1:0];
      end
      psort_pkg::ST_OUT: begin
        ram_raddr = k_r[ADDR_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // counters, set bookkeeping and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psort_pkg::ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      jd_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_final_r <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == psort_pkg::ST_OUT);
      out_final_r <= (state_r == psort_pkg::ST_OUT) && out_end;
      out_ovf_r   <= dropped_r;
      case (state_r)
        psort_pkg::ST_IDLE: begin
          if (accept) begin
            if (room) count_r <= count_r + CNT_W'(1);
            else      dropped_r <= 1'b1;
            i_r <= '0;
            k_r <= '0;
          end
        end
        psort_pkg::ST_RDI: begin
          j_r <= i_r + CNT_W'(1);
        end
        psort_pkg::ST_HOLD, psort_pkg::ST_SCAN: begin
          jd_r <= j_r;
          j_r  <= j_r + CNT_W'(1);
        end
        psort_pkg::ST_WBI: begin
          i_r <= i_r + CNT_W'(1);
        end
        psort_pkg::ST_OUT: begin
          k_r <= k_r + CNT_W'(1);
          if (out_end) begin
            count_r   <= '0;
            dropped_r <= 1'b0;
          end
        end
        default: begin
          i_r <= '0;
        end
      endcase
    end
  end

  assign busy      = (state_r != psort_pkg::ST_IDLE);
  assign rec_idx   = psort_pkg::IDX_W'(count_r);
  assign out_valid = out_valid_r;
  assign out_final = out_final_r;
  assign out_ovf   = out_ovf_r;

endmodule
`default_nettype wire

// ----- tb/sv/tb_pay_exchange_sorter.sv -----
module tb_pay_exchange_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP    = psort_pkg::MAX_RECORDS_DEF;
  localparam int DAYS_W = psort_pkg::DAYS_W;
  localparam int WAGE_W = psort_pkg::WAGE_W;
  localparam int PAY_W  = psort_pkg::PAY_W;
  localparam int IDX_W  = psort_pkg::IDX_W;

  // how the content of a random record is chosen
  localparam int PICK_WIDE = 0;
  localparam int PICK_TIES = 1;
  localparam int PICK_EDGE = 2;
  localparam int PICK_MIX  = 3;

  // one expected result of a closed set
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PAY_W-1:0] pay;
    logic             fin;
    logic             ovf;
  } payslip_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [DAYS_W-1:0] in_days_worked = '0;
  logic [WAGE_W-1:0] in_daily_wage = '0;
  logic              in_last_record = 1'b0;
  logic              out_valid;
  logic [IDX_W-1:0]  out_record_index;
  logic [PAY_W-1:0]  out_net_pay;
  logic              out_final_result;
  logic              out_overflow;

  pay_exchange_sorter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_days_worked   (in_days_worked),
    .in_daily_wage    (in_daily_wage),
    .in_last_record   (in_last_record),
    .out_valid        (out_valid),
    .out_record_index (out_record_index),
    .out_net_pay      (out_net_pay),
    .out_final_result (out_final_result),
    .out_overflow     (out_overflow)
  );

  always #4 clk = ~clk;

  // predictor copy of the record store
  logic [PAY_W-1:0] held_pay [0:CAP-1];
  logic [IDX_W-1:0] held_idx [0:CAP-1];
  int               held_count = 0;
  bit               held_dropped = 1'b0;
  payslip_t         due_payslips [$];

  int errors = 0;
  int records_sent = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int payslips_seen = 0;
  payslip_t want;

  // store one accepted record; on the last one sort and queue the payslips
  task automatic book_record(input logic [DAYS_W-1:0] d, input logic [WAGE_W-1:0] w,
                             input logic l);
    logic [PAY_W-1:0] dx;
    logic [PAY_W-1:0] wx;
    logic [PAY_W-1:0] tp;
    logic [IDX_W-1:0] ti;
    payslip_t         slip;
    dx = PAY_W'(d);
    wx = PAY_W'(w);
    if (held_count < CAP) begin
      held_pay[held_count] = dx * wx;
      held_idx[held_count] = held_count[IDX_W-1:0];
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (l) begin
      // exchange sort, strict compare keeps the tie order of the block
      for (int i = 0; i < held_count; i++) begin
        for (int j = i + 1; j < held_count; j++) begin
          if (held_pay[j] > held_pay[i]) begin
            tp = held_pay[i];
            ti = held_idx[i];
            held_pay[i] = held_pay[j];
            held_idx[i] = held_idx[j];
            held_pay[j] = tp;
            held_idx[j] = ti;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        slip.idx = held_idx[k];
        slip.pay = held_pay[k];
        slip.fin = (k == held_count - 1);
        slip.ovf = held_dropped;
        due_payslips.push_back(slip);
      end
      sets_closed++;
      if (held_dropped) overflow_sets++;
      held_count = 0;
      held_dropped = 1'b0;
    end
  endtask

  // present one request and hold it until the block takes it
  task automatic send_record(input logic [DAYS_W-1:0] d, input logic [WAGE_W-1:0] w,
                             input logic l);
    start          <= 1'b1;
    in_days_worked <= d;
    in_daily_wage  <= w;
    in_last_record <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    book_record(d, w, l);
    records_sent++;
  endtask

  // drop start for a burst, with junk on the fields
  task automatic idle_burst();
    start          <= 1'b0;
    in_days_worked <= DAYS_W'($urandom);
    in_daily_wage  <= WAGE_W'($urandom);
    in_last_record <= 1'($urandom);
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 2) == 0) idle_burst();
  endtask

  task automatic pick_record(input int mode, output logic [DAYS_W-1:0] d,
                             output logic [WAGE_W-1:0] w);
    int m;
    m = mode;
    if (m == PICK_MIX) m = int'($urandom_range(PICK_WIDE, PICK_EDGE));
    case (m)
      PICK_TIES: begin
        d = DAYS_W'($urandom_range(0, 3));
        w = WAGE_W'($urandom_range(0, 3));
      end
      PICK_EDGE: begin
        d = $urandom_range(0, 1) ? {DAYS_W{1'b1}} : DAYS_W'($urandom_range(0, 1));
        w = $urandom_range(0, 1) ? {WAGE_W{1'b1}} : WAGE_W'($urandom_range(0, 1));
      end
      default: begin
        d = DAYS_W'($urandom_range(0, 1023));
        w = WAGE_W'($urandom);
      end
    endcase
  endtask

  // one whole set of n records, last one flagged
  task automatic send_set(input int n, input int mode, input bit idle_ok);
    logic [DAYS_W-1:0] d;
    logic [WAGE_W-1:0] w;
    for (int k = 0; k < n; k++) begin
      maybe_idle(idle_ok);
      pick_record(mode, d, w);
      send_record(d, w, k == n - 1);
    end
  endtask

  // field extremes, alternating bit patterns, and a one-record set
  task automatic test_extremes();
    send_record(10'd0, 32'd0, 1'b0);
    send_record(10'h3FF, 32'hFFFF_FFFF, 1'b0);
    send_record(10'd0, 32'hFFFF_FFFF, 1'b0);
    send_record(10'h3FF, 32'd0, 1'b0);
    idle_burst();
    send_record(10'h2AA, 32'h5555_5555, 1'b0);
    send_record(10'h155, 32'hAAAA_AAAA, 1'b0);
    send_record(10'd1, 32'd1, 1'b0);
    send_record(10'h3FF, 32'hFFFF_FFFE, 1'b1);
    idle_burst();
    send_record(10'h3FF, 32'hFFFF_FFFF, 1'b1);
  endtask

  // equal pays from different factors, so the tie order shows
  task automatic test_ties();
    send_record(10'd3, 32'd4, 1'b0);
    send_record(10'd2, 32'd6, 1'b0);
    send_record(10'd6, 32'd2, 1'b0);
    send_record(10'd12, 32'd1, 1'b0);
    send_record(10'd0, 32'd5, 1'b0);
    send_record(10'd1, 32'd12, 1'b0);
    send_record(10'd4, 32'd3, 1'b0);
    send_record(10'd0, 32'd0, 1'b0);
    send_record(10'd7, 32'd1, 1'b0);
    send_record(10'd1, 32'd7, 1'b1);
  endtask

  // single-record sets with start held high through the busy phase
  task automatic test_back_to_back();
    send_record(10'd5, 32'd9, 1'b1);
    send_record(10'd0, 32'd0, 1'b1);
    send_record(10'h3FF, 32'd1, 1'b1);
  endtask

  // a set that fills the store and then drops the last two, closing record included
  task automatic test_capacity();
    idle_burst();
    send_set(CAP + 2, PICK_MIX, 1'b1);
  endtask

  // random sets, mostly small; the tail runs without gaps
  task automatic test_random();
    int target;
    int n;
    target = records_sent + 21;
    while (records_sent < target) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
      if (n > target - records_sent) n = target - records_sent;
      send_set(n, PICK_MIX, records_sent < target - 8);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // compare each strobed result with the oldest payslip due
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      payslips_seen++;
      if (due_payslips.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got idx %0d pay %0h", $time,
                 out_record_index, out_net_pay);
      end else begin
        want = due_payslips.pop_front();
        check_field("record_index", 64'(want.idx), 64'(out_record_index));
        check_field("net_pay", 64'(want.pay), 64'(out_net_pay));
        check_field("final_result", 64'(want.fin), 64'(out_final_result));
        check_field("overflow", 64'(want.ovf), 64'(out_overflow));
      end
    end
  end

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_ties();
    test_back_to_back();
    test_capacity();
    test_random();
    start <= 1'b0;

    // drain outstanding payslips, then let the block settle
    waited = 0;
    while (due_payslips.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (due_payslips.size() != 0) begin
      errors++;
      $display("%0t: %0d results missing, expected idx %0d pay %0h, got none", $time,
               due_payslips.size(), due_payslips[0].idx, due_payslips[0].pay);
    end

    $display("Sent %0d records in %0d sets (%0d with dropped records).", records_sent,
             sets_closed, overflow_sets);
    $display("Checked %0d sorted results, %0d errors.", payslips_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Timeout: run did not complete");
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/psort_pkg.sv
sv/psort_ram.sv
sv/psort_dp.sv
sv/psort_seq.sv
sv/pay_exchange_sorter.sv
tb/sv/tb_pay_exchange_sorter.sv
